[rtl/core/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared constants, types and helpers for the running median stream block.
// ----------------------------------------------------------------------------
package rms_pkg;

  // Default sizing
  localparam int RMS_CAPACITY   = 1024;
  localparam int RMS_VALUE_BITS = 20;

  // Select tree: each registered node ORs 2**TREE_RADIX_LOG children
  localparam int TREE_RADIX_LOG = 4;
  localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DONE
  } rms_state_t;

  // Number of registered tree stages for a given cell count
  function automatic int tree_levels(input int capacity);
    int bits;
    bits = $clog2(capacity);
    return (bits + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
  endfunction

  // Offset of a stage (1-based) in the flat node array
  function automatic int tree_off(input int pad, input int stage);
    int off;
    off = 0;
    for (int s = 1; s < stage; s++) begin
      off = off + (pad >> (TREE_RADIX_LOG * s));
    end
    return off;
  endfunction

endpackage

[rtl/core/rms_cell.sv]
// ----------------------------------------------------------------------------
// rms_cell
// One slot of the sorted insertion chain. Holds one sample; on insert it
// keeps its value, takes its left neighbor's value, or takes the new sample.
// ----------------------------------------------------------------------------
module rms_cell
  import rms_pkg::*;
#(
  parameter int VALUE_BITS = RMS_VALUE_BITS,
  parameter int CNT_W      = $clog2(RMS_CAPACITY + 1),
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  ins_en,
  input  logic [VALUE_BITS-1:0] sample,
  input  logic [CNT_W-1:0]      count,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_gt,
  output logic [VALUE_BITS-1:0] val,
  output logic                  gt
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  // An empty slot ranks above every sample; new sample goes after equals
  assign gt  = (count <= CNT_W'(CELL_IDX)) || (val_r > sample);
  assign val = val_r;

  // Shift right past the insertion point, drop the sample at it
  always_comb begin
    val_nxt = val_r;
    if (ins_en && gt) begin
      val_nxt = left_gt ? left_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[rtl/core/rms_select.sv]
// ----------------------------------------------------------------------------
// rms_select
// Reads one cell of the chain by index through a registered OR tree; the
// selected cell's value passes each registered stage on its way to the root.
// ----------------------------------------------------------------------------
module rms_select
  import rms_pkg::*;
#(
  parameter int CAPACITY   = RMS_CAPACITY,
  parameter int VALUE_BITS = RMS_VALUE_BITS
) (
  input  logic                        clk,
  input  logic [$clog2(CAPACITY)-1:0] sel,
  input  logic [VALUE_BITS-1:0]       cell_val [CAPACITY],
  output logic [VALUE_BITS-1:0]       root
);

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LEVELS     = tree_levels(CAPACITY);
  localparam int PAD        = 1 << (TREE_RADIX_LOG * LEVELS);
  localparam int TREE_NODES = tree_off(PAD, LEVELS + 1);

  logic [VALUE_BITS-1:0] leaf   [PAD];
  logic [VALUE_BITS-1:0] tree_r [TREE_NODES];

  // Gate each cell by its index; padding leaves stay zero
  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_real
      assign leaf[j] = (sel == IDX_W'(j)) ? cell_val[j] : '0;
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Registered OR stages, one radix group per node
  for (genvar s = 1; s <= LEVELS; s++) begin : g_stage
    localparam int OFF  = tree_off(PAD, s);
    localparam int PREV = tree_off(PAD, s - 1);
    for (genvar j = 0; j < (PAD >> (TREE_RADIX_LOG * s)); j++) begin : g_node
      logic [VALUE_BITS-1:0] acc;
      if (s == 1) begin : g_first
        always_comb begin
          acc = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            acc = acc | leaf[TREE_RADIX * j + k];
          end
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            acc = acc | tree_r[PREV + TREE_RADIX * j + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        tree_r[OFF + j] <= acc;
      end
    end
  end

  assign root = tree_r[TREE_NODES-1];

endmodule

[rtl/core/running_median_stream.sv]
// ----------------------------------------------------------------------------
// running_median_stream
// Running median of an unsigned sample stream. Samples are kept in ascending
// order in a chain of insertion cells; the two middle cells are read through
// registered select trees and summed into twice the median.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                            Direction
//  -------  -----------------------------------------------  ---------
//  in       in_valid, in_stall, in_sample                    sink
//  out      out_valid, out_stall, out_median_doubled,        source
//           out_stored_count, out_dropped
//
//  A transaction is accepted in ST_IDLE, waits in ST_FILL while the select
//  trees settle, and is loaded into the output register from ST_DONE.
//  Insertion into the cell chain happens in the accept cycle.
//  Synchronous active-low reset empties the store; cell contents are not reset.
//  A stalled result waits in the output register; the next input transaction
//  is taken meanwhile and its result waits in the select trees.
//
module running_median_stream
  import rms_pkg::*;
#(
  parameter int CAPACITY   = RMS_CAPACITY,
  parameter int VALUE_BITS = RMS_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VALUE_BITS:0]           out_median_doubled,
  output logic [$clog2(CAPACITY+1)-1:0] out_stored_count,
  output logic                          out_dropped
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int WAIT_W = $clog2(LEVELS + 1);

  rms_state_t state_r, state_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  lo_idx_r, lo_idx_nxt;
  logic [IDX_W-1:0]  hi_idx_r, hi_idx_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic              pend_drop_r, pend_drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VALUE_BITS:0]  out_med_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_drop_r;

  logic                  in_acc;
  logic                  full;
  logic                  ins_en;
  logic                  load;
  logic [CNT_W-1:0]      n_new;
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic                  cell_gt  [CAPACITY];
  logic [VALUE_BITS-1:0] lo_val;
  logic [VALUE_BITS-1:0] hi_val;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign ins_en   = in_acc && !full;
  assign n_new    = full ? count_r : count_r + CNT_W'(1);
  assign load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Insertion chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      rms_cell #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .CELL_IDX   (i)
      ) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .sample   (in_sample),
        .count    (count_r),
        .left_val ('0),
        .left_gt  (1'b0),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end else begin : g_body
      rms_cell #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .CELL_IDX   (i)
      ) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .sample   (in_sample),
        .count    (count_r),
        .left_val (cell_val[i-1]),
        .left_gt  (cell_gt[i-1]),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end
  end

  // Middle-cell readout
  rms_select #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_sel_lo (
    .clk      (clk),
    .sel      (lo_idx_r),
    .cell_val (cell_val),
    .root     (lo_val)
  );

  rms_select #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_sel_hi (
    .clk      (clk),
    .sel      (hi_idx_r),
    .cell_val (cell_val),
    .root     (hi_val)
  );

  // Sequencer: accept, let the trees settle, hand off the result
  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    count_nxt     = count_r;
    lo_idx_nxt    = lo_idx_r;
    hi_idx_nxt    = hi_idx_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_drop_nxt = pend_drop_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt     = ST_FILL;
          wait_nxt      = WAIT_W'(LEVELS);
          count_nxt     = n_new;
          lo_idx_nxt    = IDX_W'((n_new - CNT_W'(1)) >> 1);
          hi_idx_nxt    = IDX_W'(n_new >> 1);
          pend_cnt_nxt  = n_new;
          pend_drop_nxt = full;
        end
      end
      ST_FILL: begin
        wait_nxt = wait_r - WAIT_W'(1);
        if (wait_r == WAIT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold transaction payload and result payload
  always_ff @(posedge clk) begin
    lo_idx_r    <= lo_idx_nxt;
    hi_idx_r    <= hi_idx_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    pend_drop_r <= pend_drop_nxt;
    if (load) begin
      out_med_r  <= {1'b0, lo_val} + {1'b0, hi_val};
      out_cnt_r  <= pend_cnt_r;
      out_drop_r <= pend_drop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_stored_count   = out_cnt_r;
  assign out_dropped        = out_drop_r;

  // Checks
  a_full_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> (count_r == $past(count_r)))
    else $error("count changed on a dropped sample");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside of done state");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_med_r))
    else $error("stalled result changed");

endmodule
